// ===== hdl/mmcs_pkg.sv =====
// Shared types and constants for the min/max contrast stretch block.
// Used by mmcs_ctrl, mmcs_dp and min_max_contrast_stretch; no dependencies.
package mmcs_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned PROD_W    = 2 * PIX_W;
  localparam int unsigned DIV_STEPS = PIX_W;

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_MIN = '0;

  // action codes carried in tuser bit 0
  localparam logic ACT_MEASURE   = 1'b0;
  localparam logic ACT_TRANSFORM = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic measure;   // fold input pixel into min/max
    logic load;      // capture transform pixel
    logic mul;       // form scaled numerator and range flags
    logic prep;      // seed remainder, detect quotient overflow
    logic step;      // one restoring division step
    logic emit;      // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/mmcs_ctrl.sv =====
// Sequencer for the contrast stretch: input handshake, division step count,
// output hand-off. Depends on mmcs_pkg.
module mmcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_ready_o,
  input  mmcs_pkg::sts_t sts_i,
  output mmcs_pkg::cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(mmcs_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mmcs_pkg::DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    cnt_d         = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == mmcs_pkg::ACT_TRANSFORM) begin
            cmd_o.load = 1'b1;
            state_d    = ST_MUL;
          end else begin
            cmd_o.measure = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/mmcs_dp.sv =====
// Datapath for the contrast stretch: min/max tracking, scaling multiply,
// restoring divider and output register. Depends on mmcs_pkg.
module mmcs_dp #(
  parameter int unsigned FULL_SCALE = 255
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mmcs_pkg::cmd_t             cmd_i,
  output mmcs_pkg::sts_t             sts_o,
  input  logic [mmcs_pkg::PIX_W-1:0] in_pixel_i,
  input  logic                       in_frame_start_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mmcs_pkg::PIX_W-1:0] out_pixel_o,
  output logic                       out_flat_o
);

  localparam int unsigned W  = mmcs_pkg::PIX_W;
  localparam int unsigned PW = mmcs_pkg::PROD_W;
  localparam logic [W-1:0] SCALE = W'(FULL_SCALE);

  logic [W-1:0]  min_q, min_d, max_q, max_d;
  logic [W-1:0]  pix_q;
  logic [PW-1:0] num_q;
  logic [W-1:0]  span_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic          flat_q, below_q, ovf_q;
  logic          out_valid_q;
  logic [W-1:0]  out_pixel_q;
  logic          out_flat_q;

  logic [W-1:0]  base_min, base_max;
  logic [W:0]    trial;
  logic [W:0]    trial_diff;
  logic [W-1:0]  res_pixel;

  // frame start reopens the range before the pixel is folded in
  always_comb begin
    base_min = in_frame_start_i ? mmcs_pkg::PIX_MAX : min_q;
    base_max = in_frame_start_i ? mmcs_pkg::PIX_MIN : max_q;
    min_d    = (in_pixel_i < base_min) ? in_pixel_i : base_min;
    max_d    = (in_pixel_i > base_max) ? in_pixel_i : base_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= mmcs_pkg::PIX_MAX;
      max_q <= mmcs_pkg::PIX_MIN;
    end else if (cmd_i.measure) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign trial      = {rem_q, num_q[PW-1]};
  assign trial_diff = trial - {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= in_pixel_i;
    end
    if (cmd_i.mul) begin
      flat_q  <= (max_q <= min_q);
      below_q <= (pix_q < min_q);
      span_q  <= max_q - min_q;
      num_q   <= PW'(pix_q - min_q) * PW'(SCALE);
    end
    if (cmd_i.prep) begin
      // quotient above the pixel range when the high byte already covers span
      ovf_q <= (num_q[PW-1:W] >= span_q);
      rem_q <= num_q[PW-1:W];
      num_q <= {num_q[W-1:0], {W{1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.step) begin
      num_q <= {num_q[PW-2:0], 1'b0};
      if (!trial_diff[W]) begin
        rem_q <= trial_diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (flat_q || below_q) begin
      res_pixel = mmcs_pkg::PIX_MIN;
    end else if (ovf_q) begin
      res_pixel = mmcs_pkg::PIX_MAX;
    end else begin
      res_pixel = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pixel_q <= res_pixel;
      out_flat_q  <= flat_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_pixel_o    = out_pixel_q;
  assign out_flat_o     = out_flat_q;

endmodule

// ===== hdl/min_max_contrast_stretch.sv =====
// Top level of the min/max linear contrast stretch for 8-bit gray pixels.
// Depends on mmcs_pkg, mmcs_ctrl and mmcs_dp.
//
//  channel   dir  tdata                  tuser (lowest bit up)
//  s_axis    in   [7:0] pixel            [0] action, [1] frame_start
//  m_axis    out  [7:0] stretched_pixel  [0] flat_range
//
// A measure word keeps the controller idle, ready for the next word.
// A transform word runs from accept to output through capture, multiply,
// divider seed, 8 restoring steps of the divider, output load.
// Reset leaves min at 255 and max at 0, so a transform before any measure
// reports a flat range. A stalled output holds the final load only; the
// next word may be accepted while a result waits.
module min_max_contrast_stretch #(
  parameter int unsigned FULL_SCALE = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] pixel
  input  logic [1:0] s_axis_tuser_i,   // [0] action, [1] frame_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] stretched_pixel
  output logic       m_axis_tuser_o    // [0] flat_range
);

  mmcs_pkg::cmd_t cmd;
  mmcs_pkg::sts_t sts;

  mmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i[0]),
    .in_ready_o  (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mmcs_dp #(
    .FULL_SCALE (FULL_SCALE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_pixel_i       (s_axis_tdata_i),
    .in_frame_start_i (s_axis_tuser_i[1]),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_pixel_o      (m_axis_tdata_o),
    .out_flat_o       (m_axis_tuser_o)
  );

  // flat range always forces a zero pixel
  a_flat_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 8'd0))
    else $error("flat range word with nonzero pixel");

  // a transform word blocks input while the divider runs
  a_xform_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == mmcs_pkg::ACT_TRANSFORM))
      |=> !s_axis_tready_o)
    else $error("input accepted during transform");

  // a measure word finishes in its own cycle
  a_measure_fast : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == mmcs_pkg::ACT_MEASURE))
      |=> s_axis_tready_o)
    else $error("measure word stalled input");

endmodule
